// ===== hw/rtl/cnm_pkg.sv =====
//------------------------------------------------------------------------------
// cnm_pkg: shared types and constants of the cellular noise map.
// Holds the payload structs, command and status codes and controller states.
//------------------------------------------------------------------------------
package cnm_pkg;

	localparam int MaxPoints = 64;
	localparam int PtW       = 6;
	localparam int CntW      = 7;
	localparam int FracBits  = 8;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_ADD     = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FEW   = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_INVERT = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] coord_x;
		logic [7:0] coord_y;
	} in_word_t;

	typedef struct packed {
		logic [15:0] value;
		logic [1:0]  status;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PT_RD,
		S_DIST,
		S_SQRT,
		S_PT_NEXT,
		S_COMBINE,
		S_MUL,
		S_STORE,
		S_RD_MEM,
		S_RD_SETUP,
		S_DIV,
		S_DONE
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic start_pixel;  // reset pixel scan, F1/F2
		logic next_pixel;   // advance pixel counters
		logic clr_extremes;
		logic rd_point;     // register point table read
		logic calc_dist;    // register squared distance
		logic sqrt_start;
		logic sqrt_step;
		logic upd_min;      // fold distance into F1/F2, advance point
		logic mul_start;
		logic mul_step;
		logic combine;      // form pixel value
		logic store;        // write pixel and update extremes
		logic commit;       // publish extremes
		logic rd_mem;       // read pixel store at input address
		logic div_setup;
		logic div_step;
	} ctl_t;

	typedef struct packed {
		logic pt_last;      // current point is the last one
		logic sqrt_done;
		logic mul_done;
		logic pix_last;     // current pixel is the last in the grid
		logic div_done;
	} sts_t;

endpackage

// ===== hw/rtl/cnm_ctrl.sv =====
//------------------------------------------------------------------------------
// cnm_ctrl: command sequencer of the cellular noise map.
// Walks the pixel and point loops of a compute and the steps of a read.
//------------------------------------------------------------------------------
module cnm_ctrl import cnm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go_compute,
	input  logic     go_read,
	input  logic     use_mul,
	input  sts_t     sts,
	output ctl_t     ctl,
	output logic     busy,
	output logic     finish
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		finish  = 1'b0;
		busy    = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (go_compute) begin
					ctl.start_pixel  = 1'b1;
					ctl.clr_extremes = 1'b1;
					state_d = S_PT_RD;
				end else if (go_read) begin
					ctl.rd_mem = 1'b1;
					state_d = S_RD_MEM;
				end
			end
			S_PT_RD: begin
				ctl.rd_point = 1'b1;
				state_d = S_DIST;
			end
			S_DIST: begin
				ctl.calc_dist = 1'b1;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				ctl.sqrt_start = 1'b1;
				state_d = S_PT_NEXT;
			end
			S_PT_NEXT: begin
				if (!sts.sqrt_done) ctl.sqrt_step = 1'b1;
				else begin
					ctl.upd_min = 1'b1;
					state_d = sts.pt_last ? S_COMBINE : S_PT_RD;
				end
			end
			S_COMBINE: begin
				if (use_mul) begin
					ctl.mul_start = 1'b1;
					state_d = S_MUL;
				end else begin
					ctl.combine = 1'b1;
					state_d = S_STORE;
				end
			end
			S_MUL: begin
				if (!sts.mul_done) ctl.mul_step = 1'b1;
				else begin
					ctl.combine = 1'b1;
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				ctl.store = 1'b1;
				if (sts.pix_last) begin
					ctl.commit = 1'b1;
					state_d = S_DONE;
				end else begin
					ctl.next_pixel = 1'b1;
					state_d = S_PT_RD;
				end
			end
			S_RD_MEM: begin
				state_d = S_RD_SETUP;
			end
			S_RD_SETUP: begin
				ctl.div_setup = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				if (!sts.div_done) ctl.div_step = 1'b1;
				else state_d = S_DONE;
			end
			S_DONE: begin
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/cnm_datapath.sv =====
//------------------------------------------------------------------------------
// cnm_datapath: point table, distance, root, multiply, pixel store, divider.
// Bit-serial root, multiplier and divider are shared by all pixels.
//------------------------------------------------------------------------------
module cnm_datapath import cnm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  logic        pt_we,
	input  logic [PtW-1:0] pt_waddr,
	input  logic [7:0]  in_x,
	input  logic [7:0]  in_y,
	input  logic [CntW-1:0] pt_count,
	input  logic [1:0]  sel,
	input  logic        invert,
	input  logic [8:0]  eff_w,
	input  logic [8:0]  eff_h,
	output logic        flat,
	output logic [15:0] norm_value
);

	// Point table.
	logic [7:0] fx_mem [MaxPoints];
	logic [7:0] fy_mem [MaxPoints];
	logic [7:0] fx_q, fy_q;
	logic [PtW:0] pt_idx_q;

	always_ff @(posedge clk) begin
		if (pt_we) begin
			fx_mem[pt_waddr] <= in_x;
			fy_mem[pt_waddr] <= in_y;
		end
		if (ctl.rd_point) begin
			fx_q <= fx_mem[pt_idx_q[PtW-1:0]];
			fy_q <= fy_mem[pt_idx_q[PtW-1:0]];
		end
	end

	// Pixel counters.
	logic [7:0] px_q, py_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0; py_q <= '0; pt_idx_q <= '0;
		end else begin
			if (ctl.start_pixel) begin
				px_q <= '0; py_q <= '0; pt_idx_q <= '0;
			end else if (ctl.next_pixel) begin
				pt_idx_q <= '0;
				if ({1'b0, px_q} == eff_w - 9'd1) begin
					px_q <= '0;
					py_q <= py_q + 8'd1;
				end else px_q <= px_q + 8'd1;
			end else if (ctl.upd_min) pt_idx_q <= pt_idx_q + 1'b1;
		end
	end

	assign sts.pt_last  = ({1'b0, pt_idx_q} + 8'd1) >= {1'b0, pt_count};
	assign sts.pix_last = ({1'b0, px_q} == eff_w - 9'd1) &&
		({1'b0, py_q} == eff_h - 9'd1);

	// Squared distance, 17 bits, shifted by 2*FracBits for the root.
	logic [7:0]  dx, dy;
	logic [16:0] dsq_q;
	assign dx = (fx_q > px_q) ? fx_q - px_q : px_q - fx_q;
	assign dy = (fy_q > py_q) ? fy_q - py_q : py_q - fy_q;
	always_ff @(posedge clk) begin
		if (ctl.calc_dist)
			dsq_q <= {1'b0, 16'(dx) * 16'(dx)} + {1'b0, 16'(dy) * 16'(dy)};
	end

	// Bit-serial integer root of dsq << 16, 34-bit radicand, one bit a cycle.
	localparam int RadW = 18 + 2 * FracBits;
	localparam int RootW = (RadW + 1) / 2;
	logic [RadW-1:0]   rad_q;
	logic [RootW+1:0]  rem_q;
	logic [RootW-1:0]  root_q;
	logic [4:0]        sq_cnt_q;
	logic [RootW+1:0]  trial, rem_sh;
	assign rem_sh = {rem_q[RootW-1:0], rad_q[RadW-1 -: 2]};
	assign trial  = rem_sh - {root_q, 2'b01};
	assign sts.sqrt_done = (sq_cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sq_cnt_q <= '0;
		else if (ctl.sqrt_start) sq_cnt_q <= 5'(RootW);
		else if (ctl.sqrt_step) sq_cnt_q <= sq_cnt_q - 5'd1;
	end
	always_ff @(posedge clk) begin
		if (ctl.sqrt_start) begin
			rad_q  <= {1'b0, dsq_q, {(2 * FracBits){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (ctl.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (!trial[RootW+1]) begin
				rem_q  <= trial;
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	// F1/F2 tracking; all ones stands for no distance.
	logic [RootW-1:0] f1_q, f2_q;
	logic f2_none_q;
	always_ff @(posedge clk) begin
		if (ctl.start_pixel || ctl.next_pixel) begin
			f1_q <= '1; f2_q <= '1; f2_none_q <= 1'b1;
		end else if (ctl.upd_min) begin
			if (root_q < f1_q || (f2_none_q && pt_idx_q == '0)) begin
				f2_q <= f1_q;
				f1_q <= root_q;
				f2_none_q <= (pt_idx_q == '0);
			end else if (root_q < f2_q || f2_none_q) begin
				f2_q <= root_q;
				f2_none_q <= 1'b0;
			end
		end
	end

	// Shift-add multiplier F1*F2, one bit a cycle.
	logic [2*RootW-1:0] prod_q, mcand_q;
	logic [RootW-1:0]   mplier_q;
	logic [4:0]         mul_cnt_q;
	assign sts.mul_done = (mul_cnt_q == 5'd0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_cnt_q <= '0;
		else if (ctl.mul_start) mul_cnt_q <= 5'(RootW);
		else if (ctl.mul_step) mul_cnt_q <= mul_cnt_q - 5'd1;
	end
	always_ff @(posedge clk) begin
		if (ctl.mul_start) begin
			prod_q   <= '0;
			mcand_q  <= {{RootW{1'b0}}, f1_q};
			mplier_q <= f2_q;
		end else if (ctl.mul_step) begin
			if (mplier_q[0]) prod_q <= prod_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	// Pixel value; distances and the shifted product both fit in 32 bits.
	logic [31:0] pix_q;
	logic [2*RootW-FracBits-1:0] prod_sh;
	assign prod_sh = prod_q[2*RootW-1:FracBits];
	always_ff @(posedge clk) begin
		if (ctl.combine) begin
			if (sel == 2'd1) pix_q <= 32'(f2_q - f1_q);
			else if (sel == 2'd2) pix_q <= 32'(prod_sh);
			else pix_q <= 32'(f1_q);
		end
	end

	// Pixel store and extremes.
	logic [31:0] pix_mem [65536];
	logic [31:0] rd_q;
	logic [31:0] lo_run_q, hi_run_q, lo_q, hi_q;
	always_ff @(posedge clk) begin
		if (ctl.store) pix_mem[{py_q, px_q}] <= pix_q;
		if (ctl.rd_mem) rd_q <= pix_mem[{in_y, in_x}];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '1; hi_q <= '0; lo_run_q <= '1; hi_run_q <= '0;
		end else if (ctl.clr_extremes) begin
			lo_run_q <= '1; hi_run_q <= '0;
		end else if (ctl.store) begin
			if (pix_q < lo_run_q) lo_run_q <= pix_q;
			if (pix_q > hi_run_q) hi_run_q <= pix_q;
			if (ctl.commit) begin
				lo_q <= (pix_q < lo_run_q) ? pix_q : lo_run_q;
				hi_q <= (pix_q > hi_run_q) ? pix_q : hi_run_q;
			end
		end
	end
	assign flat = !(hi_q > lo_q);

	// Restoring divider: (v-lo)*65535 / (hi-lo), one quotient bit a cycle.
	logic [31:0] vc;
	logic [47:0] num_q;
	logic [32:0] drem_q;
	logic [31:0] den_q;
	logic [15:0] quo_q;
	logic [5:0]  div_cnt_q;
	logic [32:0] drem_sh, dtrial;
	assign vc = (rd_q < lo_q) ? lo_q : ((rd_q > hi_q) ? hi_q : rd_q);
	assign drem_sh = {drem_q[31:0], num_q[47]};
	assign dtrial  = drem_sh - {1'b0, den_q};
	assign sts.div_done = (div_cnt_q == 6'd0);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_cnt_q <= '0;
		else if (ctl.div_setup) div_cnt_q <= 6'd48;
		else if (ctl.div_step) div_cnt_q <= div_cnt_q - 6'd1;
	end
	always_ff @(posedge clk) begin
		if (ctl.div_setup) begin
			num_q  <= {vc - lo_q, 16'd0} - {16'd0, vc - lo_q};
			den_q  <= hi_q - lo_q;
			drem_q <= '0;
			quo_q  <= '0;
		end else if (ctl.div_step) begin
			num_q <= num_q << 1;
			if (!dtrial[32]) begin
				drem_q <= dtrial;
				quo_q  <= {quo_q[14:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				quo_q  <= {quo_q[14:0], 1'b0};
			end
		end
	end
	assign norm_value = invert ? 16'hFFFF - quo_q : quo_q;

endmodule

// ===== hw/rtl/cellular_noise_map.sv =====
//------------------------------------------------------------------------------
// cellular_noise_map: Worley cellular noise over a pixel grid.
// Loads feature points, computes a per-pixel F1/F2 map, reads normalized pixels.
//------------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  in_word_t (command, coord_x, coord_y)
// out      output     out_valid/out_ready out_word_t (value, status)
// apb      input      psel/penable       mode, invert, grid_width, grid_height
//
// Clear and add register their result word in the cycle after acceptance.
// A read runs the bit-serial 48-step divider.
// A compute runs, per pixel, a 17-step root per point plus, in product
// mode, the bit-serial product, over width*height pixels.
// Reset clears the controller, point count, extremes and map flag; the point
// table and pixel store hold no reset; the point table is read only where written.
// One word is processed at a time; the output register frees input once taken.
module cellular_noise_map import cnm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic [1:0] mode_q;
	logic       invert_q;
	logic [8:0] width_q, height_q;
	logic       cfg_we;
	reg_t       cfg_idx;
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; invert_q <= 1'b0; width_q <= 9'd256; height_q <= 9'd256;
		end else if (cfg_we && paddr[1:0] == 2'b00) begin
			unique case (cfg_idx)
				REG_MODE:   mode_q   <= pwdata[1:0];
				REG_INVERT: invert_q <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MODE:   prdata = {30'd0, mode_q};
			REG_INVERT: prdata = {31'd0, invert_q};
			REG_WIDTH:  prdata = {23'd0, width_q};
			REG_HEIGHT: prdata = {23'd0, height_q};
			default:    prdata = '0;
		endcase
	end

	// Effective settings: grid saturates to 1..256, mode 3 acts as mode 0.
	logic [8:0] eff_w, eff_h;
	logic [1:0] sel;
	assign eff_w = (width_q == '0) ? 9'd1 : (width_q > 9'd256 ? 9'd256 : width_q);
	assign eff_h = (height_q == '0) ? 9'd1 : (height_q > 9'd256 ? 9'd256 : height_q);
	assign sel   = (mode_q == 2'd3) ? 2'd0 : mode_q;

	// Point count and map flag.
	logic [CntW-1:0] count_q;
	logic            map_ready_q;
	logic            busy, finish, flat;
	logic [15:0]     norm_value;
	ctl_t            ctl;
	sts_t            sts;

	// Result register: one held word; input is taken only when it is free.
	logic      ovalid_q;
	out_word_t oword_q;
	logic      pend_q;      // a long operation is in flight
	stat_t     pstat_q;
	logic      pread_q;     // in-flight operation is a read with a value

	assign in_ready  = !ovalid_q && !busy && !pend_q;
	assign out_valid = ovalid_q;
	assign out_data  = oword_q;

	logic  acc;
	cmd_t  cmd;
	logic  coord_bad, is_few;
	assign acc = in_valid && in_ready;
	assign cmd = cmd_t'(in_data.command);
	assign coord_bad = ({1'b0, in_data.coord_x} >= eff_w) ||
		({1'b0, in_data.coord_y} >= eff_h);
	assign is_few = (count_q == '0) || (sel != 2'd0 && count_q < 7'd2);

	logic go_compute, go_read;
	assign go_compute = acc && cmd == CMD_COMPUTE && !is_few;
	assign go_read    = acc && cmd == CMD_READ && map_ready_q && !coord_bad && !flat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; map_ready_q <= 1'b0; ovalid_q <= 1'b0;
			pend_q <= 1'b0; pstat_q <= ST_OK; pread_q <= 1'b0;
			oword_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (acc) begin
				unique case (cmd)
					CMD_CLEAR: begin
						count_q <= '0;
						ovalid_q <= 1'b1;
						oword_q <= '{value: 16'd0, status: ST_OK};
					end
					CMD_ADD: begin
						ovalid_q <= 1'b1;
						if (coord_bad) oword_q <= '{value: 16'd0, status: ST_RANGE};
						else if (count_q >= 7'(MaxPoints))
							oword_q <= '{value: 16'd0, status: ST_FULL};
						else begin
							count_q <= count_q + 7'd1;
							oword_q <= '{value: 16'd0, status: ST_OK};
						end
					end
					CMD_COMPUTE: begin
						if (is_few) begin
							ovalid_q <= 1'b1;
							oword_q <= '{value: 16'd0, status: ST_FEW};
						end else begin
							pend_q <= 1'b1; pread_q <= 1'b0; pstat_q <= ST_OK;
						end
					end
					CMD_READ: begin
						if (go_read) begin
							pend_q <= 1'b1; pread_q <= 1'b1; pstat_q <= ST_OK;
						end else begin
							ovalid_q <= 1'b1;
							oword_q <= '{value: 16'd0,
								status: !map_ready_q ? ST_FEW : (coord_bad ? ST_RANGE : ST_OK)};
						end
					end
					default: ;
				endcase
			end
			if (finish) begin
				pend_q   <= 1'b0;
				ovalid_q <= 1'b1;
				oword_q  <= '{value: pread_q ? norm_value : 16'd0, status: pstat_q};
				if (!pread_q) map_ready_q <= 1'b1;
			end
		end
	end

	cnm_ctrl u_ctrl (
		.clk, .arst_n, .go_compute, .go_read,
		.use_mul(sel == 2'd2), .sts, .ctl, .busy, .finish
	);

	cnm_datapath u_dp (
		.clk, .arst_n, .ctl, .sts,
		.pt_we(acc && cmd == CMD_ADD && !coord_bad && count_q < 7'(MaxPoints)),
		.pt_waddr(count_q[PtW-1:0]),
		.in_x(in_data.coord_x), .in_y(in_data.coord_y),
		.pt_count(count_q), .sel, .invert(invert_q),
		.eff_w, .eff_h, .flat, .norm_value
	);

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready) else $error("input taken while busy");
	a_finish_pend: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> pend_q) else $error("finish without operation");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 7'(MaxPoints)) else $error("point count overflow");
`endif

endmodule
